### sv/lfu_pkg.sv
// shared types, constants and field widths for the lfu cache
`default_nettype none
package lfu_pkg;

   // field widths
   localparam int unsigned CFG_W   = 5;
   localparam int unsigned KEY_W   = 32;
   localparam int unsigned VAL_W   = 32;
   localparam int unsigned CNT_W   = 32;
   localparam int unsigned STAMP_W = 48;

   // default entry count and reset value of the entry limit
   localparam int unsigned ENTRIES_DEF = 16;
   localparam logic [CFG_W-1:0] LIMIT_RESET = 5'd16;

   // operation codes
   typedef enum logic {
      CMD_GET = 1'b0,
      CMD_PUT = 1'b1
   } cmd_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // one stored entry
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VAL_W-1:0]   value;
      logic [CNT_W-1:0]   count;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

endpackage
`default_nettype wire

### sv/lfu_req_if.sv
// request channel: command, key and put value
`default_nettype none
interface lfu_req_if;
   import lfu_pkg::*;

   logic               valid;
   logic               ready;
   logic               cmd;
   logic [KEY_W-1:0]   lookup_key;
   logic [VAL_W-1:0]   put_value;

   modport source (output valid, output cmd, output lookup_key, output put_value,
                   input ready);
   modport sink (input valid, input cmd, input lookup_key, input put_value,
                 output ready);
   modport monitor (input valid, input ready, input cmd, input lookup_key,
                    input put_value);
endinterface
`default_nettype wire

### sv/lfu_rsp_if.sv
// response channel: hit flag, read value and eviction report
`default_nettype none
interface lfu_rsp_if;
   import lfu_pkg::*;

   logic               valid;
   logic               ready;
   logic               hit;
   logic [VAL_W-1:0]   read_value;
   logic               evicted;
   logic [KEY_W-1:0]   evicted_key;

   modport source (output valid, output hit, output read_value, output evicted,
                   output evicted_key, input ready);
   modport sink (input valid, input hit, input read_value, input evicted,
                 input evicted_key, output ready);
   modport monitor (input valid, input ready, input hit, input read_value,
                    input evicted, input evicted_key);
endinterface
`default_nettype wire

### sv/lfu_cache_lookup_replace_unit.sv
// lfu cache top level: entry scan sequencer, valid bits and response register
//
// Fully associative key/value cache with least-frequently-used replacement.
// req_chan carries one word per operation: cmd (get or put), lookup_key and
// put_value. rsp_chan returns one word per request: hit, read_value, evicted
// and evicted_key. csr_wr_en / csr_wr_data set the entry limit (reset 16,
// values above ENTRIES act as ENTRIES, zero disables the cache); write it
// only while no request is in flight.
// A request walks the entry memory one slot per cycle through a single read
// port, matching keys and ranking eviction candidates by count then stamp,
// then commits the update in the finish state. A new request is taken only
// once the previous one has scanned the memory and committed.
// The response sits in an output register, so the next request is accepted
// while it waits; if rsp_chan stalls, the next commit waits in its final
// cycle until the register is free.
// Reset clears valid bits and the global stamp and returns the limit to 16;
// the entry memory itself needs no clearing, since only valid slots are used.
`default_nettype none
module lfu_cache_lookup_replace_unit
   import lfu_pkg::*;
#(
   parameter int unsigned ENTRIES = ENTRIES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   lfu_req_if.sink               req_chan,
   lfu_rsp_if.source             rsp_chan,
   input  wire logic             csr_wr_en,
   input  wire logic [CFG_W-1:0] csr_wr_data
);

   localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam int unsigned OW = (CW > CFG_W) ? CW : CFG_W;

   state_type state_ff, state_in;

   logic [CFG_W-1:0]   limit_ff;
   logic [STAMP_W-1:0] gstamp_ff, gstamp_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;

   logic               cmd_ff, cmd_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VAL_W-1:0]   val_ff, val_in;

   logic [CW-1:0]      issue_ff, issue_in;
   logic               pend_ff, pend_in;
   logic [IW-1:0]      pend_idx_ff, pend_idx_in;
   logic [CW-1:0]      used_ff, used_in;

   logic               found_ff, found_in;
   logic [IW-1:0]      found_idx_ff, found_idx_in;
   entry_type          found_ent_ff, found_ent_in;
   logic               vic_ff, vic_in;
   logic [IW-1:0]      vic_idx_ff, vic_idx_in;
   entry_type          vic_ent_ff, vic_ent_in;
   logic               free_ff, free_in;
   logic [IW-1:0]      free_idx_ff, free_idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [VAL_W-1:0]   rsp_value_ff, rsp_value_in;
   logic               rsp_evict_ff, rsp_evict_in;
   logic [KEY_W-1:0]   rsp_evkey_ff, rsp_evkey_in;

   // sequencer outputs
   logic               req_ready;
   logic               scan_issue;
   logic               fin_fire;
   logic               out_free;

   // ram ports
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   entry_type          wr_ent;
   logic [ENTRY_W-1:0] rd_data;
   entry_type          rd_ent;

   // effective limit and occupancy
   logic [OW-1:0]      limit_ext;
   logic [OW-1:0]      eff_limit;
   logic               take_vic;

   assign rd_ent = entry_type'(rd_data);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign limit_ext = OW'(limit_ff);
   assign eff_limit = (limit_ext > OW'(ENTRIES)) ? OW'(ENTRIES) : limit_ext;

   // rank compare: smaller count wins, then older stamp
   assign take_vic = !vic_ff
                     || (rd_ent.count < vic_ent_ff.count)
                     || ((rd_ent.count == vic_ent_ff.count)
                         && (rd_ent.stamp < vic_ent_ff.stamp));

   // entry memory
   lfu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_lfu_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_addr (issue_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((issue_ff == CW'(ENTRIES)) && !pend_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready  = 1'b0;
      scan_issue = 1'b0;
      fin_fire   = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready  = 1'b1;
         ST_SCAN:   scan_issue = (issue_ff < CW'(ENTRIES));
         ST_FINISH: fin_fire   = out_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req_chan.ready = req_ready;

   // scan datapath and commit
   always_comb begin
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      used_in      = used_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      found_ent_in = found_ent_ff;
      vic_in       = vic_ff;
      vic_idx_in   = vic_idx_ff;
      vic_ent_in   = vic_ent_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      valid_in     = valid_ff;
      gstamp_in    = gstamp_ff;
      wr_en        = 1'b0;
      wr_addr      = found_idx_ff;
      wr_ent       = found_ent_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_value_in = rsp_value_ff;
      rsp_evict_in = rsp_evict_ff;
      rsp_evkey_in = rsp_evkey_ff;

      // take a request and clear the scan trackers
      if (req_ready && req_chan.valid) begin
         cmd_in   = req_chan.cmd;
         key_in   = req_chan.lookup_key;
         val_in   = req_chan.put_value;
         issue_in = '0;
         used_in  = '0;
         found_in = 1'b0;
         vic_in   = 1'b0;
         free_in  = 1'b0;
      end

      // issue one read per cycle
      if (scan_issue) begin
         issue_in    = issue_ff + CW'(1);
         pend_in     = 1'b1;
         pend_idx_in = issue_ff[IW-1:0];
      end

      // examine the slot whose data just returned
      if (pend_ff) begin
         if (valid_ff[pend_idx_ff]) begin
            used_in = used_ff + CW'(1);
            if (!found_ff && (rd_ent.key == key_ff)) begin
               found_in     = 1'b1;
               found_idx_in = pend_idx_ff;
               found_ent_in = rd_ent;
            end
            if (take_vic) begin
               vic_in     = 1'b1;
               vic_idx_in = pend_idx_ff;
               vic_ent_in = rd_ent;
            end
         end else if (!free_ff) begin
            free_in     = 1'b1;
            free_idx_in = pend_idx_ff;
         end
      end

      // commit the update and load the response register
      if (fin_fire) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = 1'b0;
         rsp_value_in = '0;
         rsp_evict_in = 1'b0;
         rsp_evkey_in = '0;
         if (eff_limit != '0) begin
            if (found_ff) begin
               // hit: bump count, restamp, overwrite value on put
               rsp_hit_in = 1'b1;
               gstamp_in  = gstamp_ff + STAMP_W'(1);
               wr_en      = 1'b1;
               wr_addr    = found_idx_ff;
               wr_ent     = found_ent_ff;
               if (found_ent_ff.count != '1) begin
                  wr_ent.count = found_ent_ff.count + CNT_W'(1);
               end
               wr_ent.stamp = gstamp_in;
               if (cmd_ff == CMD_PUT) begin
                  wr_ent.value = val_ff;
               end else begin
                  rsp_value_in = found_ent_ff.value;
               end
            end else if (cmd_ff == CMD_PUT) begin
               // miss on put: evict when full, else fill the lowest free slot
               if ((OW'(used_ff) >= eff_limit) && vic_ff) begin
                  wr_en        = 1'b1;
                  wr_addr      = vic_idx_ff;
                  rsp_evict_in = 1'b1;
                  rsp_evkey_in = vic_ent_ff.key;
               end else if (free_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = free_idx_ff;
               end
               if (wr_en) begin
                  gstamp_in         = gstamp_ff + STAMP_W'(1);
                  valid_in[wr_addr] = 1'b1;
                  wr_ent.key        = key_ff;
                  wr_ent.value      = val_ff;
                  wr_ent.count      = CNT_W'(1);
                  wr_ent.stamp      = gstamp_in;
               end
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         gstamp_ff    <= '0;
         valid_ff     <= '0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gstamp_ff    <= gstamp_in;
         valid_ff     <= valid_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      pend_idx_ff  <= pend_idx_in;
      used_ff      <= used_in;
      found_ff     <= found_in;
      found_idx_ff <= found_idx_in;
      found_ent_ff <= found_ent_in;
      vic_ff       <= vic_in;
      vic_idx_ff   <= vic_idx_in;
      vic_ent_ff   <= vic_ent_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
      rsp_evict_ff <= rsp_evict_in;
      rsp_evkey_ff <= rsp_evkey_in;
   end

   // response channel
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.read_value  = rsp_value_ff;
   assign rsp_chan.evicted     = rsp_evict_ff;
   assign rsp_chan.evicted_key = rsp_evkey_ff;

endmodule
`default_nettype wire

### sv/lfu_ram.sv
// generic single write port ram with registered read
`default_nettype none
module lfu_ram
   import lfu_pkg::*;
#(
   parameter int unsigned WIDTH = ENTRY_W,
   parameter int unsigned DEPTH = ENTRIES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

### sv/lfu_checker.sv
// port-level checks for the lfu cache, bound to the top level
`default_nettype none
module lfu_checker
   import lfu_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic             rsp_hit,
   input wire logic [VAL_W-1:0] rsp_read_value,
   input wire logic             rsp_evicted,
   input wire logic [KEY_W-1:0] rsp_evicted_key
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_hit) && $stable(rsp_read_value)
          && $stable(rsp_evicted) && $stable(rsp_evicted_key)))
      else $error("response changed while stalled");

   // ready drops right after a request is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a scan was running");

   // an eviction only comes from a miss
   a_evict_is_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> !rsp_hit)
      else $error("eviction reported on a hit");

   // a returned value implies a hit
   a_value_needs_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_read_value != '0)) |-> rsp_hit)
      else $error("read value without a hit");

   // an evicted key is only reported with an eviction
   a_evkey_needs_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_evicted_key != '0)) |-> rsp_evicted)
      else $error("evicted key without an eviction");

endmodule

bind lfu_cache_lookup_replace_unit lfu_checker u_lfu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_hit         (rsp_chan.hit),
   .rsp_read_value  (rsp_chan.read_value),
   .rsp_evicted     (rsp_chan.evicted),
   .rsp_evicted_key (rsp_chan.evicted_key)
);
`default_nettype wire
